@@ rtl/sptu_pkg.sv @@
// ---------------------------------------------------------------------------
// sptu_pkg: shared types and constants for the screen-to-plane unprojector
// Widths of the fixed-point datapath, status codes, register reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package sptu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    // affine sum: two floored products plus one coefficient
    localparam int CW        = 2 * DATA_W - FRAC_BITS + 2;
    localparam int CL        = (CW + 1) / 2;
    localparam int CH        = CW - CL;
    localparam int PW        = DATA_W + CW;
    localparam int DW        = PW + 1;
    localparam int NW        = DW + FRAC_BITS;
    localparam int RW        = DW + DATA_W;
    localparam int N_REGS    = 8;
    localparam int IDX_W     = $clog2(N_REGS);
    localparam int CFG_W     = 2 * DATA_W;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int N_PROD    = 6;
    localparam int ST_W      = 2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT  = 2'd2;

    localparam logic [CFG_W-1:0] COEF_RST [N_REGS] = '{
        64'd65536, 64'd0, 64'd281474976710656, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'd281474976710656
    };

    // mat[row][col], rows and columns counted from zero
    typedef logic [3:0][3:0][DATA_W-1:0] t_mat;
    // the four affine sums c1..c4 at index 0..3
    typedef logic [3:0][CW-1:0] t_cvec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

@@ rtl/sptu_front.sv @@
// ---------------------------------------------------------------------------
// sptu_front: input side of the unprojector
// Accepts screen points and forms the four affine sums in two stages.
// ---------------------------------------------------------------------------
`default_nettype none

module sptu_front
    import sptu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [DATA_W-1:0] i_world_x,
    input  wire logic [DATA_W-1:0] i_world_y,
    input  wire t_mat              i_mat,
    input  wire t_qstat            i_qstat,
    output logic                   o_push,
    output t_cvec                  o_c
);

    logic                        r_f1_vld;
    logic                        r_f2_vld;
    logic signed [2*DATA_W-1:0]  r_px [4];
    logic signed [2*DATA_W-1:0]  r_py [4];
    t_cvec                       r_c;
    logic                        w_adv;

    assign w_adv   = !r_f2_vld || !i_qstat.full;
    assign o_ready = w_adv;
    assign o_push  = r_f2_vld && !i_qstat.full;
    assign o_c     = r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
        end else if (w_adv) begin
            r_f1_vld <= i_valid;
            r_f2_vld <= r_f1_vld;
        end
    end

    // Products are exact; the arithmetic shift floors them to the fraction width.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int n = 0; n < 4; n++) begin
                r_px[n] <= $signed(i_world_x) * $signed(i_mat[0][n]);
                r_py[n] <= $signed(i_world_y) * $signed(i_mat[1][n]);
                r_c[n]  <= CW'(r_px[n] >>> FRAC_BITS) + CW'(r_py[n] >>> FRAC_BITS)
                         + CW'($signed(i_mat[3][n]));
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/sptu_queue.sv @@
// ---------------------------------------------------------------------------
// sptu_queue: short queue between the front and back of the unprojector
// Holds affine-sum words so that either side can stall on its own.
// ---------------------------------------------------------------------------
`default_nettype none

module sptu_queue
    import sptu_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_cvec i_data,
    input  wire logic  i_pop,
    output t_cvec      o_data,
    output t_qstat     o_stat
);

    t_cvec               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QPTR_W:0]     r_cnt;

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sptu_div.sv @@
// ---------------------------------------------------------------------------
// sptu_div: pipelined restoring divider
// One quotient bit per stage; flags quotients that need more than 32 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module sptu_div
    import sptu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [NW-1:0]     i_num,
    input  wire logic [DW-1:0]     i_den,
    output logic [DATA_W-1:0]      o_quo,
    output logic                   o_ovf
);

    logic [RW-1:0]     r_rem [DATA_W];
    logic [DW-1:0]     r_den [DATA_W];
    logic [DATA_W-1:0] r_quo [DATA_W+1];
    logic              r_ovf [DATA_W+1];

    assign o_quo = r_quo[DATA_W];
    assign o_ovf = r_ovf[DATA_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(i_num);
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= (RW'(i_num) >= {i_den, {DATA_W{1'b0}}});
        end
    end

    for (genvar k = 0; k < DATA_W; k++) begin : g_step
        localparam int B = DATA_W - 1 - k;
        logic [RW:0]       w_trial;
        logic [DATA_W-1:0] n_quo;

        assign w_trial = {1'b0, r_rem[k]} - {1'b0, RW'(r_den[k]) << B};

        always_comb begin
            n_quo    = r_quo[k];
            n_quo[B] = !w_trial[RW];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k+1] <= n_quo;
                r_ovf[k+1] <= r_ovf[k];
            end
        end

        if (k < DATA_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= w_trial[RW] ? r_rem[k] : w_trial[RW-1:0];
                    r_den[k+1] <= r_den[k];
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/sptu_back.sv @@
// ---------------------------------------------------------------------------
// sptu_back: execution side of the unprojector
// Cross products, denominator check, two divisions, saturation, result word.
// ---------------------------------------------------------------------------
`default_nettype none

module sptu_back
    import sptu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mat              i_mat,
    input  wire t_cvec             i_c,
    input  wire t_qstat            i_qstat,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [DATA_W-1:0]      o_local_x,
    output logic [DATA_W-1:0]      o_local_y,
    output logic [ST_W-1:0]        o_status
);

    localparam int LAT = 4 + DATA_W + 1;

    typedef struct packed {
        logic zero;
        logic neg_x;
        logic neg_y;
    } t_side;

    logic                           w_adv;
    logic [LAT-1:0]                 r_vld;
    logic                           r_out_vld;
    logic [DATA_W-1:0]              w_m [N_PROD];
    logic [CW-1:0]                  w_c [N_PROD];
    logic signed [DATA_W+CL:0]      r_plo [N_PROD];
    logic signed [DATA_W+CH-1:0]    r_phi [N_PROD];
    logic signed [PW-1:0]           r_prod [N_PROD];
    logic signed [DW-1:0]           r_den, r_nx, r_ny;
    logic [DW-1:0]                  r_dmag;
    logic [NW-1:0]                  r_xnum, r_ynum;
    t_side                          r_b4;
    t_side                          r_side [DATA_W+1];
    logic [DATA_W-1:0]              w_qx, w_qy;
    logic                           w_ovx, w_ovy;
    logic [DATA_W-1:0]              w_limx, w_limy, w_sx, w_sy;
    logic                           w_satx, w_saty;
    logic [DATA_W-1:0]              r_lx, r_ly;
    logic [ST_W-1:0]                r_st;

    assign w_adv     = !r_out_vld || i_ready;
    assign o_pop     = w_adv && !i_qstat.empty;
    assign o_valid   = r_out_vld;
    assign o_local_x = r_lx;
    assign o_local_y = r_ly;
    assign o_status  = r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[LAT-2:0], !i_qstat.empty};
            r_out_vld <= r_vld[LAT-1];
        end
    end

    // den = m34*c3 - m33*c4, nx = m31*c3 - m33*c1, ny = m32*c3 - m33*c2
    always_comb begin
        w_m[0] = i_mat[2][3];  w_c[0] = i_c[2];
        w_m[1] = i_mat[2][2];  w_c[1] = i_c[3];
        w_m[2] = i_mat[2][0];  w_c[2] = i_c[2];
        w_m[3] = i_mat[2][2];  w_c[3] = i_c[0];
        w_m[4] = i_mat[2][1];  w_c[4] = i_c[2];
        w_m[5] = i_mat[2][2];  w_c[5] = i_c[1];
    end

    // The wide products are split in two halves of the sum operand; the
    // registered halves are recombined into r_prod.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < N_PROD; j++) begin
                r_plo[j]  <= $signed(w_m[j]) * $signed({1'b0, w_c[j][CL-1:0]});
                r_phi[j]  <= $signed(w_m[j]) * $signed(w_c[j][CW-1:CL]);
                r_prod[j] <= (PW'(r_phi[j]) <<< CL) + PW'(r_plo[j]);
            end
            r_den <= DW'(r_prod[0]) - DW'(r_prod[1]);
            r_nx  <= DW'(r_prod[2]) - DW'(r_prod[3]);
            r_ny  <= DW'(r_prod[4]) - DW'(r_prod[5]);

            r_dmag     <= r_den[DW-1] ? DW'(-r_den) : DW'(r_den);
            r_xnum     <= {(r_nx[DW-1] ? DW'(-r_nx) : DW'(r_nx)), {FRAC_BITS{1'b0}}};
            r_ynum     <= {(r_ny[DW-1] ? DW'(-r_ny) : DW'(r_ny)), {FRAC_BITS{1'b0}}};
            r_b4.zero  <= (r_den == '0);
            r_b4.neg_x <= r_nx[DW-1] ^ r_den[DW-1];
            r_b4.neg_y <= r_ny[DW-1] ^ r_den[DW-1];

            r_side[0] <= r_b4;
            for (int k = 1; k <= DATA_W; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    sptu_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_xnum),
        .i_den (r_dmag),
        .o_quo (w_qx),
        .o_ovf (w_ovx)
    );

    sptu_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_ynum),
        .i_den (r_dmag),
        .o_quo (w_qy),
        .o_ovf (w_ovy)
    );

    always_comb begin
        w_limx = r_side[DATA_W].neg_x ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        w_limy = r_side[DATA_W].neg_y ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        w_satx = w_ovx || (w_qx > w_limx);
        w_saty = w_ovy || (w_qy > w_limy);
        w_sx   = w_satx ? w_limx : w_qx;
        w_sy   = w_saty ? w_limy : w_qy;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_side[DATA_W].zero) begin
                r_lx <= '0;
                r_ly <= '0;
                r_st <= ST_ZERO;
            end else begin
                r_lx <= r_side[DATA_W].neg_x ? -w_sx : w_sx;
                r_ly <= r_side[DATA_W].neg_y ? -w_sy : w_sy;
                r_st <= (w_satx || w_saty) ? ST_SAT : ST_OK;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/screen_to_plane_unproject_core.sv @@
// ---------------------------------------------------------------------------
// screen_to_plane_unproject_core: screen point to local plane unprojection
// Maps a signed Q16.16 screen point onto an element's local z=0 plane.
// ---------------------------------------------------------------------------
// The block takes one screen point word per clock while o_ready is high and
// returns one result word per point, in order, through two front stages, the
// queue, four product and sign stages, 33 divider stages and the output
// register. Throughput is one point per clock when the output is taken; each
// stage, the 32 quotient bit stages of both dividers included, holds a point.
// The front forms the four affine sums and parks them in a four-entry queue,
// so it keeps accepting points while a finished result waits in the output
// register; the back stalls as a whole when the output is not taken. The
// inverse matrix lives in eight 64-bit registers written through the config
// port, which is always ready; write them only while the block is empty.
// Status is 0 for a good result, 1 when the denominator is zero (both
// coordinates then read zero), and 2 when either quotient was clamped.
`default_nettype none

module screen_to_plane_unproject_core
    import sptu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [DATA_W-1:0] i_world_x,
    input  wire logic [DATA_W-1:0] i_world_y,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [DATA_W-1:0]      o_local_x,
    output logic [DATA_W-1:0]      o_local_y,
    output logic [ST_W-1:0]        o_status
);

    logic [CFG_W-1:0] r_coef [N_REGS];
    t_mat             w_mat;
    t_cvec            w_push_c;
    t_cvec            w_head_c;
    t_qstat           w_qstat;
    logic             w_push;
    logic             w_pop;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_REGS; i++) begin
                r_coef[i] <= COEF_RST[i];
            end
        end else if (i_cfg_valid) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    // Each register holds two entries of one row: the even column in the low
    // half and the odd column in the high half.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                w_mat[r][c] = r_coef[IDX_W'(r * 2 + (c >> 1))][(c & 1) * DATA_W +: DATA_W];
            end
        end
    end

    sptu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_world_x (i_world_x),
        .i_world_y (i_world_y),
        .i_mat     (w_mat),
        .i_qstat   (w_qstat),
        .o_push    (w_push),
        .o_c       (w_push_c)
    );

    sptu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_c),
        .i_pop   (w_pop),
        .o_data  (w_head_c),
        .o_stat  (w_qstat)
    );

    sptu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mat     (w_mat),
        .i_c       (w_head_c),
        .i_qstat   (w_qstat),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_local_x (o_local_x),
        .o_local_y (o_local_y),
        .o_status  (o_status)
    );

endmodule

`default_nettype wire

@@ rtl/sptu_chk.sv @@
// ---------------------------------------------------------------------------
// sptu_chk: port-level checks for the unprojector
// Watches the result channel over time and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module sptu_chk
    import sptu_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic [DATA_W-1:0] o_local_x,
    input wire logic [DATA_W-1:0] o_local_y,
    input wire logic [ST_W-1:0]   o_status
);

    // A result word waiting for the sink keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_local_x) && $stable(o_local_y)
                                && $stable(o_status))
        else $error("result word changed while stalled");

    // Reset empties the pipeline.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A zero denominator gives the origin.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_ZERO |-> o_local_x == '0 && o_local_y == '0)
        else $error("zero denominator with non-zero coordinates");

    // A clamped result sits on one of the range limits.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_SAT |->
            o_local_x == {1'b1, {(DATA_W-1){1'b0}}} || o_local_x == {1'b0, {(DATA_W-1){1'b1}}}
            || o_local_y == {1'b1, {(DATA_W-1){1'b0}}}
            || o_local_y == {1'b0, {(DATA_W-1){1'b1}}})
        else $error("saturated status without a clamped coordinate");

endmodule

bind screen_to_plane_unproject_core sptu_chk u_chk (.*);

`default_nettype wire
